FILE: rtl/core/shtm_pkg.sv
// Shared types, constants and helper functions for the two-wire sensor
// measurement transaction unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shtm_pkg;

    // Width of the hold/poll wait counter.
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    localparam int TICK_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] POLL_CNT_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STATUS_NIBBLE = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [TICK_BITS-1:0] RST_HALF_PERIOD   = 16'd10;
    localparam logic [TICK_BITS-1:0] RST_POLL_INTERVAL = 16'd5000;
    localparam logic [7:0]           RST_POLL_LIMIT    = 8'd62;
    localparam logic [3:0]           RST_STATUS_NIBBLE = 4'd0;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] command;
        logic       data_in;
    } t_in_item;

    typedef struct packed {
        logic        sck;
        logic        data_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] measured_value;
        logic [1:0]  result_status;
        logic        ack_ok;
    } t_out_item;

    typedef struct packed {
        logic [TICK_BITS-1:0] half_period;
        logic [TICK_BITS-1:0] poll_interval;
        logic [7:0]           poll_limit;
        logic [3:0]           status_nibble;
    } t_cfg;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

    // CRC-8, polynomial 0x31, one byte MSB first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        logic [7:0] d;
        logic       top;
        c = crc;
        d = v;
        for (int i = 0; i < 8; i++) begin
            top = c[7] ^ d[7];
            c   = {c[6:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

    // Wait counter load: a count of zero behaves as one, long holds saturate.
    function automatic logic [TIMER_BITS-1:0] load_wait(input logic [TICK_BITS-1:0] ticks);
        logic [31:0] t;
        t = (ticks == '0) ? 32'd0 : (32'(ticks) - 32'd1);
        if (t > 32'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return TIMER_BITS'(t);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shtm_cfg.sv
// Configuration register bank of the sensor measurement unit.
// Depends on shtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shtm_cfg
    import shtm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period   <= RST_HALF_PERIOD;
            r_cfg.poll_interval <= RST_POLL_INTERVAL;
            r_cfg.poll_limit    <= RST_POLL_LIMIT;
            r_cfg.status_nibble <= RST_STATUS_NIBBLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD:   r_cfg.half_period   <= i_cfg_data[TICK_BITS-1:0];
                CFG_POLL_INTERVAL: r_cfg.poll_interval <= i_cfg_data[TICK_BITS-1:0];
                CFG_POLL_LIMIT:    r_cfg.poll_limit    <= i_cfg_data[7:0];
                CFG_STATUS_NIBBLE: r_cfg.status_nibble <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/shtm_ctrl.sv
// Bus sequencer of the sensor measurement unit: phase machine, wait timer,
// shifter and CRC. Advances one tick per accepted beat. Depends on shtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shtm_ctrl
    import shtm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_out_item     o_result
);

    typedef enum logic [22:0] {
        PH_IDLE   = 23'h000001,
        PH_TS2    = 23'h000002,
        PH_TS3    = 23'h000004,
        PH_TS4    = 23'h000008,
        PH_TS5    = 23'h000010,
        PH_TS6    = 23'h000020,
        PH_TX_LO  = 23'h000040,
        PH_TX_DAT = 23'h000080,
        PH_TX_HI  = 23'h000100,
        PH_AK_LO  = 23'h000200,
        PH_AK_REL = 23'h000400,
        PH_AK_HI  = 23'h000800,
        PH_AK_SMP = 23'h001000,
        PH_POLL   = 23'h002000,
        PH_RD_SET = 23'h004000,
        PH_RD_SMP = 23'h008000,
        PH_K0     = 23'h010000,
        PH_K1     = 23'h020000,
        PH_K2     = 23'h040000,
        PH_K3     = 23'h080000,
        PH_CK_K2  = 23'h100000,
        PH_CK_K3  = 23'h200000,
        PH_FIN    = 23'h400000
    } t_phase;

    t_phase                r_phase,    n_phase;
    logic [1:0]            r_byte,     n_byte;
    logic [3:0]            r_bit_cnt,  n_bit_cnt;
    logic [TIMER_BITS-1:0] r_timer,    n_timer;
    logic [7:0]            r_poll_cnt, n_poll_cnt;
    logic [7:0]            r_shift,    n_shift;
    logic [7:0]            r_crc,      n_crc;
    logic [15:0]           r_value,    n_value;
    logic                  r_ack,      n_ack;
    logic                  r_sck,      n_sck;
    logic                  r_dlow,     n_dlow;

    logic [TIMER_BITS-1:0] w_hold;
    logic [TIMER_BITS-1:0] w_poll_wait;
    logic [7:0]            w_shift_smp;
    logic [3:0]            w_cnt_inc;
    logic [7:0]            w_crc_smp;
    logic [7:0]            w_crc_cmd;
    logic                  w_done;
    logic [1:0]            w_status;

    assign w_hold      = load_wait(i_cfg.half_period);
    assign w_poll_wait = load_wait(i_cfg.poll_interval);
    // Bits arrive MSB first, so bit n of the count lands at position 7-n.
    assign w_shift_smp = r_shift | ({7'd0, i_item.data_in} << (~r_bit_cnt[2:0]));
    assign w_cnt_inc   = r_bit_cnt + 4'd1;
    assign w_crc_smp   = crc_feed(r_crc, w_shift_smp);
    assign w_crc_cmd   = crc_feed(r_crc, r_shift);

    always_comb begin
        n_phase    = r_phase;
        n_byte     = r_byte;
        n_bit_cnt  = r_bit_cnt;
        n_timer    = r_timer;
        n_poll_cnt = r_poll_cnt;
        n_shift    = r_shift;
        n_crc      = r_crc;
        n_value    = r_value;
        n_ack      = r_ack;
        n_sck      = r_sck;
        n_dlow     = r_dlow;
        w_done     = 1'b0;
        w_status   = ST_OK;

        if (r_phase == PH_IDLE) begin
            if (i_item.op) begin
                n_shift    = i_item.command;
                n_value    = '0;
                n_ack      = 1'b0;
                n_bit_cnt  = '0;
                n_poll_cnt = '0;
                n_byte     = '0;
                n_crc      = mirror8({4'd0, i_cfg.status_nibble});
                n_dlow     = 1'b0;
                n_sck      = 1'b1;
                n_timer    = w_hold;
                n_phase    = PH_TS2;
            end
        end else if (r_timer != '0) begin
            n_timer = r_timer - TIMER_BITS'(1);
        end else begin
            case (r_phase)
                PH_TS2: begin
                    n_dlow = 1'b1; n_timer = w_hold; n_phase = PH_TS3;
                end
                PH_TS3: begin
                    n_sck = 1'b0; n_timer = w_hold; n_phase = PH_TS4;
                end
                PH_TS4: begin
                    n_sck = 1'b1; n_timer = w_hold; n_phase = PH_TS5;
                end
                PH_TS5: begin
                    n_dlow = 1'b0; n_timer = w_hold; n_phase = PH_TS6;
                end
                PH_TS6: begin
                    n_sck = 1'b0; n_timer = w_hold; n_bit_cnt = '0; n_phase = PH_TX_LO;
                end
                PH_TX_LO: begin
                    n_sck = 1'b0; n_timer = w_hold; n_phase = PH_TX_DAT;
                end
                PH_TX_DAT: begin
                    n_dlow  = ~r_shift[~r_bit_cnt[2:0]];
                    n_timer = w_hold;
                    n_phase = PH_TX_HI;
                end
                PH_TX_HI: begin
                    n_sck     = 1'b1;
                    n_timer   = w_hold;
                    n_bit_cnt = w_cnt_inc;
                    n_phase   = (w_cnt_inc >= 4'd8) ? PH_AK_LO : PH_TX_LO;
                end
                PH_AK_LO: begin
                    n_sck = 1'b0; n_timer = w_hold; n_phase = PH_AK_REL;
                end
                PH_AK_REL: begin
                    n_dlow = 1'b0; n_timer = w_hold; n_phase = PH_AK_HI;
                end
                PH_AK_HI: begin
                    n_sck = 1'b1; n_timer = w_hold; n_phase = PH_AK_SMP;
                end
                PH_AK_SMP: begin
                    n_ack      = ~i_item.data_in;
                    n_sck      = 1'b0;
                    n_timer    = w_hold;
                    n_crc      = w_crc_cmd;
                    n_poll_cnt = '0;
                    n_phase    = PH_POLL;
                end
                PH_POLL: begin
                    if (r_poll_cnt != '0 && r_poll_cnt >= i_cfg.poll_limit) begin
                        w_status = ST_TIMEOUT;
                        w_done   = 1'b1;
                        n_phase  = PH_IDLE;
                    end else if (!i_item.data_in) begin
                        // Conversion finished: the sensor pulled DATA low.
                        n_bit_cnt = '0;
                        n_shift   = '0;
                        n_byte    = 2'd0;
                        n_sck     = 1'b1;
                        n_timer   = w_hold;
                        n_phase   = PH_RD_SMP;
                    end else begin
                        if (r_poll_cnt < POLL_CNT_MAX) begin
                            n_poll_cnt = r_poll_cnt + 8'd1;
                        end
                        n_timer = w_poll_wait;
                    end
                end
                PH_RD_SET: begin
                    n_sck = 1'b1; n_timer = w_hold; n_phase = PH_RD_SMP;
                end
                PH_RD_SMP: begin
                    n_shift   = w_shift_smp;
                    n_sck     = 1'b0;
                    n_timer   = w_hold;
                    n_bit_cnt = w_cnt_inc;
                    if (w_cnt_inc >= 4'd8) begin
                        if (r_byte == 2'd0) begin
                            n_value = {w_shift_smp, r_value[7:0]};
                            n_crc   = w_crc_smp;
                            n_phase = PH_K0;
                        end else if (r_byte == 2'd1) begin
                            n_value = {r_value[15:8], w_shift_smp};
                            n_crc   = w_crc_smp;
                            n_phase = PH_K0;
                        end else begin
                            n_phase = PH_CK_K2;
                        end
                    end else begin
                        n_phase = PH_RD_SET;
                    end
                end
                PH_K0: begin
                    n_dlow = 1'b1; n_timer = w_hold; n_phase = PH_K1;
                end
                PH_K1: begin
                    n_sck = 1'b1; n_timer = w_hold; n_phase = PH_K2;
                end
                PH_K2: begin
                    n_sck = 1'b0; n_timer = w_hold; n_phase = PH_K3;
                end
                PH_K3: begin
                    n_dlow    = 1'b0;
                    n_timer   = w_hold;
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_byte    = r_byte + 2'd1;
                    n_phase   = PH_RD_SET;
                end
                PH_CK_K2: begin
                    n_sck = 1'b1; n_timer = w_hold; n_phase = PH_CK_K3;
                end
                PH_CK_K3: begin
                    n_sck = 1'b0; n_timer = w_hold; n_phase = PH_FIN;
                end
                PH_FIN: begin
                    // The checksum comes bit-reversed on the wire.
                    w_status = (mirror8(r_shift) == r_crc) ? ST_OK : ST_CRC_ERR;
                    w_done   = 1'b1;
                    n_phase  = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            endcase
        end
    end

    always_comb begin
        o_result.sck            = n_sck;
        o_result.data_low       = n_dlow;
        o_result.busy_res       = (n_phase != PH_IDLE);
        o_result.done_res       = w_done;
        o_result.measured_value = w_done ? r_value : 16'd0;
        o_result.result_status  = w_done ? w_status : ST_OK;
        o_result.ack_ok         = w_done ? r_ack : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_byte     <= '0;
            r_bit_cnt  <= '0;
            r_timer    <= '0;
            r_poll_cnt <= '0;
            r_shift    <= '0;
            r_crc      <= '0;
            r_value    <= '0;
            r_ack      <= 1'b0;
            r_sck      <= 1'b0;
            r_dlow     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_byte     <= n_byte;
            r_bit_cnt  <= n_bit_cnt;
            r_timer    <= n_timer;
            r_poll_cnt <= n_poll_cnt;
            r_shift    <= n_shift;
            r_crc      <= n_crc;
            r_value    <= n_value;
            r_ack      <= n_ack;
            r_sck      <= n_sck;
            r_dlow     <= n_dlow;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/shtm_outbuf.sv
// Two-entry result buffer (output register plus skid entry) of the sensor
// measurement unit. Depends on shtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shtm_outbuf
    import shtm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output t_out_item      o_item,
    input  wire logic      i_stall
);

    logic      r_vld;
    logic      r_skid_vld;
    t_out_item r_item;
    t_out_item r_skid;
    logic      w_take;

    assign w_take = r_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_item     <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_vld || w_take) begin
                r_item <= i_item;
                r_vld  <= 1'b1;
            end else begin
                r_skid     <= i_item;
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_vld <= 1'b0;
        end
    end

    assign o_full  = r_skid_vld;
    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/core/sht_sensor_measure_transaction_unit.sv
// Top level of the two-wire sensor measurement unit: configuration bank,
// bus sequencer and result buffer. Depends on shtm_pkg and the shtm_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one timing tick of the bus master and yields exactly one
// result beat carrying the line levels, busy flag and, on the finishing tick,
// the reading, status and acknowledge flag. A beat is taken in every clock
// cycle without input stall: the sequencer updates its state in the cycle the
// beat is accepted and the result enters the two-entry output buffer at the
// same edge. Input stall rises only when both buffer entries are full, that is
// after the output side has stalled; otherwise throughput is one beat per clock.
// Configuration is written through a plain write port and should change only
// while no transaction is running.
module sht_sensor_measure_transaction_unit
    import shtm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_item                 i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_out_item                     o_out_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_full;
    logic      w_step;

    assign o_in_stall = w_full;
    assign w_step     = i_in_valid && !w_full;

    shtm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    shtm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (i_in_data),
        .o_result (w_result)
    );

    shtm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_item  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: rtl/core/shtm_checker.sv
// Port-level checks for the sensor measurement unit, bound to the top level.
// Depends on shtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shtm_checker
    import shtm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // A finishing beat never reports the unit as still busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done beat shows busy");

    // Reading, status and ack are only carried on the finishing beat.
    a_quiet_when_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            o_out_data.measured_value == 16'd0 && o_out_data.result_status == ST_OK &&
            !o_out_data.ack_ok)
        else $error("result fields set outside done beat");

    // A timed-out measurement carries no reading.
    a_timeout_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res && o_out_data.result_status == ST_TIMEOUT |->
            o_out_data.measured_value == 16'd0)
        else $error("timeout beat carries a reading");

    // Input stall means the buffer is full, so a result must be on offer.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind sht_sensor_measure_transaction_unit shtm_checker u_shtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: dv/tb_sht_sensor_measure_transaction_unit.sv
// Self-checking testbench for sht_sensor_measure_transaction_unit: drives tick beats that emulate
// the sensor on the DATA line and checks every result beat against a cycle-level predictor.
// Depends on shtm_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_sht_sensor_measure_transaction_unit;
    import shtm_pkg::*;

    // Sequencer phase codes.
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_TS2     = 5'd1;
    localparam logic [4:0] PH_TS3     = 5'd2;
    localparam logic [4:0] PH_TS4     = 5'd3;
    localparam logic [4:0] PH_TS5     = 5'd4;
    localparam logic [4:0] PH_TS6     = 5'd5;
    localparam logic [4:0] PH_TX_LO   = 5'd6;
    localparam logic [4:0] PH_TX_DAT  = 5'd7;
    localparam logic [4:0] PH_TX_HI   = 5'd8;
    localparam logic [4:0] PH_AK_LO   = 5'd9;
    localparam logic [4:0] PH_AK_REL  = 5'd10;
    localparam logic [4:0] PH_AK_HI   = 5'd11;
    localparam logic [4:0] PH_AK_SMP  = 5'd12;
    localparam logic [4:0] PH_POLL    = 5'd13;
    localparam logic [4:0] PH_RD_BASE = 5'd14;
    localparam logic [4:0] PH_K_BASE  = 5'd20;
    localparam logic [4:0] PH_CK_K2   = 5'd28;
    localparam logic [4:0] PH_CK_K3   = 5'd29;
    localparam logic [4:0] PH_FIN     = 5'd30;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        logic [4:0]            phase;
        logic [3:0]            bits;
        logic [TIMER_BITS-1:0] timer;
        logic [7:0]            polls;
        logic [7:0]            shreg;
        logic [7:0]            crc;
        logic [15:0]           value;
        logic                  ack;
        logic                  sck;
        logic                  dlow;
    } t_seq_state;

    typedef struct packed {
        t_seq_state st;
        t_out_item  res;
    } t_seq_step;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_item                o_out_data;

    t_in_item   pending_beats[$];
    t_out_item  expected_beats[$];
    t_seq_state model_state;
    t_cfg       model_cfg;
    t_seq_state gen_state;
    t_cfg       gen_cfg;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ack_pct = 100;
    int poll_low_pct = 50;
    int crc_good_pct = 100;
    int noise_pct = 0;
    bit crc_good_now = 1'b1;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;

    sht_sensor_measure_transaction_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bit_reverse8(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
        end
        return acc;
    endfunction

    // A hold of n ticks leaves n-1 ticks on the counter after the action tick.
    function automatic logic [TIMER_BITS-1:0] hold_count(logic [TICK_BITS-1:0] ticks);
        longint unsigned n;
        n = (ticks == '0) ? 0 : longint'(ticks) - 1;
        if (n > longint'(TIMER_MAX)) begin
            n = longint'(TIMER_MAX);
        end
        return TIMER_BITS'(n);
    endfunction

    // One tick of the bus sequencer: next state and the result beat it produces.
    function automatic t_seq_step sequencer_next(t_seq_state s, t_cfg c, t_in_item it);
        t_seq_step             r;
        logic                  done;
        logic [1:0]            status;
        logic [4:0]            rel;
        logic [TIMER_BITS-1:0] half_ld;
        done = 1'b0;
        status = ST_OK;
        half_ld = hold_count(c.half_period);
        if (s.phase == PH_IDLE) begin
            if (it.op) begin
                s.shreg = it.command;
                s.value = '0;
                s.ack = 1'b0;
                s.bits = '0;
                s.polls = '0;
                s.crc = bit_reverse8({4'h0, c.status_nibble});
                s.dlow = 1'b0;
                s.sck = 1'b1;
                s.timer = half_ld;
                s.phase = PH_TS2;
            end
        end else if (s.timer != '0) begin
            s.timer = s.timer - 1'b1;
        end else if (s.phase >= PH_RD_BASE && s.phase < PH_K_BASE) begin
            rel = s.phase - PH_RD_BASE;
            if (!rel[0]) begin
                s.sck = 1'b1;
                s.timer = half_ld;
                s.phase = s.phase + 5'd1;
            end else begin
                if (it.data_in) begin
                    s.shreg[3'd7 - s.bits[2:0]] = 1'b1;
                end
                s.sck = 1'b0;
                s.timer = half_ld;
                s.bits = s.bits + 4'd1;
                if (s.bits >= 4'd8) begin
                    if (rel[2:1] == 2'd0) begin
                        s.value[15:8] = s.shreg;
                        s.crc = crc8_byte(s.crc, s.shreg);
                        s.phase = PH_K_BASE;
                    end else if (rel[2:1] == 2'd1) begin
                        s.value[7:0] = s.shreg;
                        s.crc = crc8_byte(s.crc, s.shreg);
                        s.phase = PH_K_BASE + 5'd4;
                    end else begin
                        s.phase = PH_CK_K2;
                    end
                end else begin
                    s.phase = s.phase - 5'd1;
                end
            end
        end else if (s.phase >= PH_K_BASE && s.phase < PH_CK_K2) begin
            rel = s.phase - PH_K_BASE;
            s.timer = half_ld;
            case (rel[1:0])
                2'd0: begin
                    s.dlow = 1'b1;
                    s.phase = s.phase + 5'd1;
                end
                2'd1: begin
                    s.sck = 1'b1;
                    s.phase = s.phase + 5'd1;
                end
                2'd2: begin
                    s.sck = 1'b0;
                    s.phase = s.phase + 5'd1;
                end
                default: begin
                    s.dlow = 1'b0;
                    s.bits = '0;
                    s.shreg = '0;
                    s.phase = PH_RD_BASE + (rel[2] ? 5'd4 : 5'd2);
                end
            endcase
        end else begin
            case (s.phase)
                PH_TS2: begin
                    s.dlow = 1'b1; s.timer = half_ld; s.phase = PH_TS3;
                end
                PH_TS3: begin
                    s.sck = 1'b0; s.timer = half_ld; s.phase = PH_TS4;
                end
                PH_TS4: begin
                    s.sck = 1'b1; s.timer = half_ld; s.phase = PH_TS5;
                end
                PH_TS5: begin
                    s.dlow = 1'b0; s.timer = half_ld; s.phase = PH_TS6;
                end
                PH_TS6: begin
                    s.sck = 1'b0; s.timer = half_ld; s.bits = '0; s.phase = PH_TX_LO;
                end
                PH_TX_LO: begin
                    s.sck = 1'b0; s.timer = half_ld; s.phase = PH_TX_DAT;
                end
                PH_TX_DAT: begin
                    s.dlow = ~s.shreg[3'd7 - s.bits[2:0]];
                    s.timer = half_ld;
                    s.phase = PH_TX_HI;
                end
                PH_TX_HI: begin
                    s.sck = 1'b1;
                    s.timer = half_ld;
                    s.bits = s.bits + 4'd1;
                    s.phase = (s.bits >= 4'd8) ? PH_AK_LO : PH_TX_LO;
                end
                PH_AK_LO: begin
                    s.sck = 1'b0; s.timer = half_ld; s.phase = PH_AK_REL;
                end
                PH_AK_REL: begin
                    s.dlow = 1'b0; s.timer = half_ld; s.phase = PH_AK_HI;
                end
                PH_AK_HI: begin
                    s.sck = 1'b1; s.timer = half_ld; s.phase = PH_AK_SMP;
                end
                PH_AK_SMP: begin
                    s.ack = ~it.data_in;
                    s.sck = 1'b0;
                    s.timer = half_ld;
                    s.crc = crc8_byte(s.crc, s.shreg);
                    s.polls = '0;
                    s.phase = PH_POLL;
                end
                PH_POLL: begin
                    // A zero limit still allows one poll since the count must be nonzero.
                    if (s.polls != '0 && s.polls >= c.poll_limit) begin
                        status = ST_TIMEOUT;
                        done = 1'b1;
                        s.phase = PH_IDLE;
                    end else if (!it.data_in) begin
                        s.bits = '0;
                        s.shreg = '0;
                        s.sck = 1'b1;
                        s.timer = half_ld;
                        s.phase = PH_RD_BASE + 5'd1;
                    end else begin
                        if (s.polls < POLL_CNT_MAX) begin
                            s.polls = s.polls + 8'd1;
                        end
                        s.timer = hold_count(c.poll_interval);
                    end
                end
                PH_CK_K2: begin
                    s.sck = 1'b1; s.timer = half_ld; s.phase = PH_CK_K3;
                end
                PH_CK_K3: begin
                    s.sck = 1'b0; s.timer = half_ld; s.phase = PH_FIN;
                end
                PH_FIN: begin
                    status = (bit_reverse8(s.shreg) == s.crc) ? ST_OK : ST_CRC_ERR;
                    done = 1'b1;
                    s.phase = PH_IDLE;
                end
                default: begin
                    s.phase = PH_IDLE;
                    s.timer = '0;
                end
            endcase
        end
        r.st = s;
        r.res.sck = s.sck;
        r.res.data_low = s.dlow;
        r.res.busy_res = (s.phase != PH_IDLE);
        r.res.done_res = done;
        r.res.measured_value = done ? s.value : 16'h0000;
        r.res.result_status = done ? status : ST_OK;
        r.res.ack_ok = done ? s.ack : 1'b0;
        return r;
    endfunction

    // Level the emulated sensor puts on DATA for the tick about to be sent.
    function automatic logic sensor_level(t_seq_state s);
        logic [7:0] good_sum;
        good_sum = bit_reverse8(s.crc);
        if (s.phase == PH_AK_HI || s.phase == PH_AK_SMP) begin
            return ($urandom_range(99) >= ack_pct);
        end
        if (s.phase == PH_POLL) begin
            return ($urandom_range(99) >= poll_low_pct);
        end
        if (crc_good_now && (s.phase == PH_RD_BASE + 5'd4 || s.phase == PH_RD_BASE + 5'd5)) begin
            return good_sum[3'd7 - s.bits[2:0]];
        end
        return 1'($urandom_range(1));
    endfunction

    // Input side: the prediction is made for each beat as it is accepted.
    always @(posedge i_clk) begin : drv
        t_seq_step nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            model_state = '0;
            model_state.phase = PH_IDLE;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                nxt = sequencer_next(model_state, model_cfg, i_in_data);
                model_state = nxt.st;
                expected_beats.push_back(nxt.res);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            if (fail_count < 40) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
            fail_count++;
        end
    endtask

    // Output side: compare each accepted result beat, then pick the next stall level.
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    if (fail_count < 40) begin
                        $display("%0t: result beat with no expectation, actual %h",
                                 $time, o_out_data);
                    end
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("sck", want.sck, o_out_data.sck);
                    check_field("data_low", want.data_low, o_out_data.data_low);
                    check_field("busy_res", want.busy_res, o_out_data.busy_res);
                    check_field("done_res", want.done_res, o_out_data.done_res);
                    check_field("measured_value", want.measured_value,
                                o_out_data.measured_value);
                    check_field("result_status", want.result_status,
                                o_out_data.result_status);
                    check_field("ack_ok", want.ack_ok, o_out_data.ack_ok);
                end
            end
            if (hold_request && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_beats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HALF_PERIOD:   model_cfg.half_period = data;
            CFG_POLL_INTERVAL: model_cfg.poll_interval = data;
            CFG_POLL_LIMIT:    model_cfg.poll_limit = data[7:0];
            default:           model_cfg.status_nibble = data[3:0];
        endcase
        gen_cfg = model_cfg;
    endtask

    // Upper bits of the narrow registers carry noise that the block must drop.
    task automatic setup_phase(int half, int interval, int limit, int nibble, int mode);
        drain();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_HALF_PERIOD, CFG_DATA_BITS'(half));
        write_reg(CFG_POLL_INTERVAL, CFG_DATA_BITS'(interval));
        write_reg(CFG_POLL_LIMIT, {8'($urandom), 8'(limit)});
        write_reg(CFG_STATUS_NIBBLE, {12'($urandom), 4'(nibble)});
        @(negedge i_clk);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    task automatic set_sensor(int ack, int poll_low, int crc_good, int noise);
        ack_pct = ack;
        poll_low_pct = poll_low;
        crc_good_pct = crc_good;
        noise_pct = noise;
    endtask

    task automatic push_tick(t_in_item it);
        t_seq_step nxt;
        nxt = sequencer_next(gen_state, gen_cfg, it);
        gen_state = nxt.st;
        pending_beats.push_back(it);
    endtask

    task automatic idle_ticks(int n);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it.op = 1'b0;
            it.command = 8'($urandom);
            it.data_in = 1'($urandom_range(1));
            push_tick(it);
        end
    endtask

    // Queue ticks until the given number of transactions has finished.
    // A negative command means a random one; pause_at drains the pipe once mid-run.
    task automatic run_transactions(int n_done, int cmd_fixed, int pause_at);
        int        finished;
        int        ticks;
        t_in_item  it;
        t_seq_step peek;
        finished = 0;
        ticks = 0;
        while (finished < n_done) begin
            it.command = (cmd_fixed < 0) ? 8'($urandom) : 8'(cmd_fixed);
            it.data_in = sensor_level(gen_state);
            it.op = 1'b0;
            if (gen_state.phase == PH_IDLE) begin
                it.op = ($urandom_range(3) == 0);
                if (it.op) begin
                    crc_good_now = ($urandom_range(99) < crc_good_pct);
                end
            end else begin
                // Starts while busy must be ignored, also on the finishing tick.
                peek = sequencer_next(gen_state, gen_cfg, it);
                if (peek.res.done_res) begin
                    it.op = 1'($urandom_range(1));
                end else begin
                    it.op = ($urandom_range(99) < noise_pct);
                end
            end
            peek = sequencer_next(gen_state, gen_cfg, it);
            if (peek.res.done_res) begin
                finished++;
            end
            push_tick(it);
            ticks++;
            if (ticks == pause_at) begin
                drain();
            end
        end
        idle_ticks($urandom_range(1, 3));
    endtask

    initial begin
        model_cfg = {RST_HALF_PERIOD, RST_POLL_INTERVAL, RST_POLL_LIMIT, RST_STATUS_NIBBLE};
        gen_cfg = model_cfg;
        gen_state = '0;
        gen_state.phase = PH_IDLE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration, sensor behaving well and finishing its conversion at once.
        set_sensor(100, 100, 100, 0);
        run_transactions(1, 8'h03, -1);

        // Zero counts act as one; zero poll limit times out after a single poll.
        setup_phase(0, 0, 0, 0, 0);
        set_sensor(100, 0, 100, 0);
        run_transactions(1, 8'hFF, -1);
        set_sensor(0, 100, 100, 0);
        run_transactions(1, 8'h00, -1);

        // Longest poll limit, then a corrupted checksum with starts while busy.
        setup_phase(1, 1, 255, 15, 0);
        set_sensor(100, 0, 100, 0);
        run_transactions(1, 8'hA5, -1);
        set_sensor(100, 100, 0, 20);
        run_transactions(1, 8'h5A, -1);

        // Largest hold values; only plain ticks, as a full transaction would take too long.
        setup_phase(65535, 65535, 1, 8, 0);
        idle_ticks(16);

        // The sender pauses partway through the transaction until every result has come.
        setup_phase(2, 20, 4, 3, 1);
        set_sensor(90, 40, 100, 10);
        run_transactions(1, -1, 80);

        for (int ph = 0; ph < 4; ph++) begin
            setup_phase($urandom_range(0, 1),
                        $urandom_range(0, 10),
                        ($urandom_range(9) == 0) ? 255 : $urandom_range(0, 6),
                        $urandom_range(15), ph % 4);
            set_sensor(85, 40, 70, 8);
            if (ph == 0) begin
                // Long output hold while the sender keeps offering beats.
                hold_request = 1'b1;
            end
            run_transactions(1, -1, -1);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
